### src/wav_header_parser_unit_macros.svh
// assertion helpers for the wav header parser
`ifndef WAV_HEADER_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define WAVHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wav header parser: same-cycle check failed");

// next-cycle implication, disabled during reset
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wav header parser: next-cycle check failed");

`endif

### src/wavhp_pkg.sv
package wavhp_pkg;

  localparam int unsigned CLK_W  = 27;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned RES_W  = 5;
  localparam int unsigned CMP_W  = 8;
  localparam int unsigned LO_W   = 5;
  localparam int unsigned PRE_SHIFT = 3;
  localparam int unsigned QUO_W  = CLK_W - PRE_SHIFT;
  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(16000000);

  localparam logic [ID_W-1:0] ID_WAVE = 32'h4556_4157;
  localparam logic [ID_W-1:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [ID_W-1:0] ID_DATA = 32'h6174_6164;
  localparam logic [ID_W-1:0] ID_LIST = 32'h5453_494C;
  localparam logic [ID_W-1:0] ID_FACT = 32'h7463_6166;

  localparam logic [CNT_W-1:0] FMT_MIN = 32'd16;
  localparam logic [CNT_W-1:0] FMT_MAX = 32'd100;

  localparam logic [BYTE_W-1:0] FMT_PCM    = 8'd1;
  localparam logic [BYTE_W-1:0] CH_MONO    = 8'd1;
  localparam logic [BYTE_W-1:0] CH_STEREO  = 8'd2;
  localparam logic [BYTE_W-1:0] RES_8      = 8'd8;
  localparam logic [BYTE_W-1:0] RES_16     = 8'd16;
  localparam logic [RATE_W-1:0] CMP_LIMIT  = 16'd255;

  // header offsets
  localparam logic [LO_W-1:0] OFF_RIFF_ID   = 5'd8;
  localparam logic [LO_W-1:0] OFF_RIFF_LAST = 5'd11;
  localparam logic [LO_W-1:0] OFF_ID_END    = 5'd4;
  localparam logic [LO_W-1:0] OFF_HDR_LAST  = 5'd7;
  localparam logic [LO_W-1:0] OFF_FMT_TAG   = 5'd0;
  localparam logic [LO_W-1:0] OFF_FMT_CH    = 5'd2;
  localparam logic [LO_W-1:0] OFF_FMT_RLO   = 5'd4;
  localparam logic [LO_W-1:0] OFF_FMT_RHI   = 5'd5;
  localparam logic [LO_W-1:0] OFF_FMT_BITS  = 5'd14;

  typedef struct packed {
    logic clear;
    logic cnt_clr;
    logic cnt_inc;
    logic shift_id;
    logic shift_size;
    logic load_stereo;
    logic load_rate_lo;
    logic load_rate_hi;
    logic load_res;
    logic div_start;
    logic emit;
    logic emit_ok;
  } cmd_t;

  typedef struct packed {
    logic [LO_W-1:0] cnt_lo;
    logic            cnt_hi_zero;
    logic            next_eq_size;
    logic            wave_nxt;
    logic            id_fmt;
    logic            id_data;
    logic            id_skip;
    logic            size_fmt_ok;
    logic            size_zero;
    logic            byte_pcm;
    logic            byte_ch_ok;
    logic            byte_res_ok;
    logic            rate_ok;
    logic            div_busy;
    logic            out_free;
  } stat_t;

endpackage

### src/wavhp_in_if.sv
interface wavhp_in_if;
  logic                         valid;
  logic                         ready;
  logic [wavhp_pkg::BYTE_W-1:0] byte_value;
  logic                         first_byte;
  logic                         last_byte;

  modport source (output valid, output byte_value, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input byte_value, input first_byte, input last_byte,
                output ready);
endinterface

### src/wavhp_out_if.sv
interface wavhp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [wavhp_pkg::CNT_W-1:0]  data_bytes;
  logic                         stereo;
  logic [wavhp_pkg::RES_W-1:0]  bits_per_sample;
  logic [wavhp_pkg::RATE_W-1:0] sample_rate;
  logic [wavhp_pkg::CMP_W-1:0]  timer_compare;
  logic                         slow_prescaler;

  modport source (output valid, output status, output data_bytes, output stereo,
                  output bits_per_sample, output sample_rate, output timer_compare,
                  output slow_prescaler, input ready);
  modport sink (input valid, input status, input data_bytes, input stereo,
                input bits_per_sample, input sample_rate, input timer_compare,
                input slow_prescaler, output ready);
endinterface

### src/wavhp_ctrl.sv
module wavhp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_first,
  input  logic                in_last,
  output logic                in_ready,
  input  wavhp_pkg::stat_t    stat,
  output wavhp_pkg::cmd_t     cmd
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RIFF = 3'd1;
  localparam logic [2:0] PH_HDR  = 3'd2;
  localparam logic [2:0] PH_FMT  = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0] phase_r;
  logic [2:0] phase_nxt;
  logic       acc;
  logic       bad;
  logic       ok;
  logic       active;

  function automatic logic cnt_is(input wavhp_pkg::stat_t s,
                                  input logic [wavhp_pkg::LO_W-1:0] k);
    return s.cnt_hi_zero && (s.cnt_lo == k);
  endfunction

  assign in_ready = !stat.div_busy && stat.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    bad       = 1'b0;
    ok        = 1'b0;
    active    = 1'b0;
    if (acc) begin
      if (in_first) begin
        // restart: this byte is file byte 0, nothing to decode yet
        cmd.clear   = 1'b1;
        cmd.cnt_inc = 1'b1;
        phase_nxt   = PH_RIFF;
        active      = 1'b1;
      end else begin
        unique case (phase_r)
          PH_RIFF: begin
            active      = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.shift_id = !(stat.cnt_hi_zero && (stat.cnt_lo < wavhp_pkg::OFF_RIFF_ID));
            if (cnt_is(stat, wavhp_pkg::OFF_RIFF_LAST)) begin
              if (stat.wave_nxt) begin
                phase_nxt   = PH_HDR;
                cmd.cnt_clr = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
          end
          PH_HDR: begin
            active         = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.shift_id   = stat.cnt_hi_zero && (stat.cnt_lo < wavhp_pkg::OFF_ID_END);
            cmd.shift_size = !cmd.shift_id;
            if (cnt_is(stat, wavhp_pkg::OFF_HDR_LAST)) begin
              cmd.cnt_clr = 1'b1;
              priority if (stat.id_fmt) begin
                if (stat.size_fmt_ok) phase_nxt = PH_FMT;
                else bad = 1'b1;
              end else if (stat.id_data) begin
                ok = 1'b1;
              end else if (stat.id_skip) begin
                if (!stat.size_zero) phase_nxt = PH_SKIP;
              end else begin
                bad = 1'b1;
              end
            end
          end
          PH_FMT: begin
            active      = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (cnt_is(stat, wavhp_pkg::OFF_FMT_TAG) && !stat.byte_pcm) bad = 1'b1;
            if (cnt_is(stat, wavhp_pkg::OFF_FMT_CH)) begin
              if (stat.byte_ch_ok) cmd.load_stereo = 1'b1;
              else bad = 1'b1;
            end
            if (cnt_is(stat, wavhp_pkg::OFF_FMT_RLO)) cmd.load_rate_lo = 1'b1;
            if (cnt_is(stat, wavhp_pkg::OFF_FMT_RHI)) begin
              cmd.load_rate_hi = 1'b1;
              if (stat.rate_ok) cmd.div_start = !in_last;
              else bad = 1'b1;
            end
            if (cnt_is(stat, wavhp_pkg::OFF_FMT_BITS)) begin
              if (stat.byte_res_ok) cmd.load_res = 1'b1;
              else bad = 1'b1;
            end
            if (!bad && stat.next_eq_size) begin
              phase_nxt   = PH_HDR;
              cmd.cnt_clr = 1'b1;
            end
          end
          PH_SKIP: begin
            active      = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.next_eq_size) begin
              phase_nxt   = PH_HDR;
              cmd.cnt_clr = 1'b1;
            end
          end
          default: begin
            active = 1'b0;
          end
        endcase
      end
      if (active && (bad || ok || in_last)) begin
        cmd.emit    = 1'b1;
        cmd.emit_ok = ok;
        phase_nxt   = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

### src/wavhp_dpath.sv
module wavhp_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wavhp_pkg::CLK_W-1:0]      cfg_wdata,
  input  logic [wavhp_pkg::BYTE_W-1:0]     in_byte,
  input  wavhp_pkg::cmd_t                  cmd,
  output wavhp_pkg::stat_t                 stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_status,
  output logic [wavhp_pkg::CNT_W-1:0]      out_data_bytes,
  output logic                             out_stereo,
  output logic [wavhp_pkg::RES_W-1:0]      out_bits,
  output logic [wavhp_pkg::RATE_W-1:0]     out_rate,
  output logic [wavhp_pkg::CMP_W-1:0]      out_cmp,
  output logic                             out_pre
);

  localparam int unsigned QW = wavhp_pkg::QUO_W;
  localparam int unsigned RW = wavhp_pkg::RATE_W;

  logic [wavhp_pkg::CLK_W-1:0]  clock_hz_r;
  logic [wavhp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_base, cnt_inc1;
  logic [wavhp_pkg::ID_W-1:0]   id_r, id_nxt, id_sh;
  logic [wavhp_pkg::CNT_W-1:0]  size_r, size_nxt, size_sh;
  logic                         stereo_r;
  logic [wavhp_pkg::RES_W-1:0]  res_r;
  logic [RW-1:0]                rate_r, rate_full;
  logic [wavhp_pkg::CMP_W-1:0]  cmp_r;
  logic                         pre_r;

  logic                         busy_r;
  logic [wavhp_pkg::STEP_W-1:0] step_r;
  logic [QW-1:0]                quo_r;
  logic [RW-1:0]                rem_r;
  logic [RW-1:0]                dvs_r;
  logic [RW:0]                  rem_sh;
  logic [RW+1:0]                diff;
  logic [RW-1:0]                v8, v64;
  logic [QW-1:0]                q64;
  logic                         big;

  logic                         out_valid_r;

  assign id_sh     = {in_byte, id_r[wavhp_pkg::ID_W-1:wavhp_pkg::BYTE_W]};
  assign size_sh   = {in_byte, size_r[wavhp_pkg::CNT_W-1:wavhp_pkg::BYTE_W]};
  assign rate_full = {in_byte, rate_r[wavhp_pkg::BYTE_W-1:0]};
  assign cnt_inc1  = cnt_r + wavhp_pkg::CNT_W'(1);

  always_comb begin
    stat              = '0;
    stat.cnt_lo       = cnt_r[wavhp_pkg::LO_W-1:0];
    stat.cnt_hi_zero  = (cnt_r[wavhp_pkg::CNT_W-1:wavhp_pkg::LO_W] == '0);
    stat.next_eq_size = (cnt_inc1 == size_r);
    stat.wave_nxt     = (id_sh == wavhp_pkg::ID_WAVE);
    stat.id_fmt       = (id_r == wavhp_pkg::ID_FMT);
    stat.id_data      = (id_r == wavhp_pkg::ID_DATA);
    stat.id_skip      = (id_r == wavhp_pkg::ID_LIST) || (id_r == wavhp_pkg::ID_FACT);
    stat.size_fmt_ok  = (size_sh >= wavhp_pkg::FMT_MIN) && (size_sh <= wavhp_pkg::FMT_MAX);
    stat.size_zero    = (size_sh == '0);
    stat.byte_pcm     = (in_byte == wavhp_pkg::FMT_PCM);
    stat.byte_ch_ok   = (in_byte == wavhp_pkg::CH_MONO) || (in_byte == wavhp_pkg::CH_STEREO);
    stat.byte_res_ok  = (in_byte == wavhp_pkg::RES_8) || (in_byte == wavhp_pkg::RES_16);
    stat.rate_ok      = (rate_full != '0);
    stat.div_busy     = busy_r;
    stat.out_free     = !out_valid_r || out_ready;
  end

  // byte counter and header shift registers
  always_comb begin
    cnt_base = cmd.clear ? '0 : cnt_r;
    priority if (cmd.cnt_clr) cnt_nxt = '0;
    else if (cmd.cnt_inc)     cnt_nxt = cnt_base + wavhp_pkg::CNT_W'(1);
    else                      cnt_nxt = cnt_base;
    priority if (cmd.clear)   id_nxt = '0;
    else if (cmd.shift_id)    id_nxt = id_sh;
    else                      id_nxt = id_r;
    priority if (cmd.clear)   size_nxt = '0;
    else if (cmd.shift_size)  size_nxt = size_sh;
    else                      size_nxt = size_r;
  end

  // restoring divider step, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign v8     = quo_r[RW-1:0] - RW'(1);
  assign big    = (v8 > wavhp_pkg::CMP_LIMIT);
  assign q64    = quo_r >> wavhp_pkg::PRE_SHIFT;
  assign v64    = q64[RW-1:0] - RW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r  <= wavhp_pkg::CLOCK_HZ_RST;
      cnt_r       <= '0;
      id_r        <= '0;
      size_r      <= '0;
      stereo_r    <= 1'b0;
      res_r       <= '0;
      rate_r      <= '0;
      cmp_r       <= '0;
      pre_r       <= 1'b0;
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) clock_hz_r <= cfg_wdata;
      cnt_r  <= cnt_nxt;
      id_r   <= id_nxt;
      size_r <= size_nxt;
      if (cmd.clear) begin
        stereo_r <= 1'b0;
        res_r    <= '0;
        rate_r   <= '0;
        cmp_r    <= '0;
        pre_r    <= 1'b0;
      end else begin
        if (cmd.load_stereo)  stereo_r <= (in_byte == wavhp_pkg::CH_STEREO);
        if (cmd.load_res)     res_r <= in_byte[wavhp_pkg::RES_W-1:0];
        if (cmd.load_rate_lo) rate_r <= {{(RW-wavhp_pkg::BYTE_W){1'b0}}, in_byte};
        if (cmd.load_rate_hi) rate_r <= rate_full;
        if (busy_r && (step_r == '0)) begin
          cmp_r <= big ? v64[wavhp_pkg::CMP_W-1:0] : v8[wavhp_pkg::CMP_W-1:0];
          pre_r <= big;
        end
      end
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        step_r <= wavhp_pkg::STEP_W'(QW);
      end else if (busy_r) begin
        if (step_r == '0) busy_r <= 1'b0;
        else step_r <= step_r - wavhp_pkg::STEP_W'(1);
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= clock_hz_r[wavhp_pkg::CLK_W-1:wavhp_pkg::PRE_SHIFT];
      rem_r <= '0;
      dvs_r <= rate_full;
    end else if (busy_r && (step_r != '0)) begin
      if (!diff[RW+1]) begin
        rem_r <= diff[RW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[RW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_status     <= !cmd.emit_ok;
      out_data_bytes <= cmd.emit_ok ? size_sh : '0;
      out_stereo     <= cmd.emit_ok && stereo_r;
      out_bits       <= cmd.emit_ok ? res_r : '0;
      out_rate       <= cmd.emit_ok ? rate_r : '0;
      out_cmp        <= cmd.emit_ok ? cmp_r : '0;
      out_pre        <= cmd.emit_ok && pre_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/wav_header_parser_unit.sv
// wav header parser: takes a wav file one byte per in_ch transaction
// (byte_value, first_byte marks byte 0, last_byte marks the end) and returns
// one out_ch transaction per file: status 0 with the data chunk size and the
// fmt chunk fields, or status 1 with all other fields zero.
// cfg_we/cfg_wdata write clock_hz, used for the timer compare value; write it
// only while no file is being parsed.
// throughput: one byte per cycle while out_ch has room, except at fmt offset 5 where the timer
// division runs on a one-bit-per-cycle restoring divider; in_ch.ready then
// stays low while it works out the 24 quotient bits and a finishing step.
// output: the result is registered and shows on out_ch in the cycle after the
// byte that decides it.
// stall: while a result waits on out_ch, in_ch.ready stays low; a result is
// replaced in the same cycle that out_ch.ready takes it.
// reset: rst_n low for one clock clears the parser to wait for a first byte,
// drops out_ch.valid and sets clock_hz to 16000000.
module wav_header_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [wavhp_pkg::CLK_W-1:0]  cfg_wdata,
  wavhp_in_if.sink                     in_ch,
  wavhp_out_if.source                  out_ch
);

  `include "wav_header_parser_unit_macros.svh"

  wavhp_pkg::cmd_t  cmd;
  wavhp_pkg::stat_t stat;
  logic             in_ready;

  wavhp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_first (in_ch.first_byte),
    .in_last  (in_ch.last_byte),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wavhp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_byte        (in_ch.byte_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_data_bytes (out_ch.data_bytes),
    .out_stereo     (out_ch.stereo),
    .out_bits       (out_ch.bits_per_sample),
    .out_rate       (out_ch.sample_rate),
    .out_cmp        (out_ch.timer_compare),
    .out_pre        (out_ch.slow_prescaler)
  );

  assign in_ch.ready = in_ready;

  `WAVHP_ASSERT_NOW(a_emit_room, clk, rst_n, cmd.emit, !out_ch.valid || out_ch.ready)
  `WAVHP_ASSERT_NEXT(a_div_busy, clk, rst_n, cmd.div_start, stat.div_busy && !in_ch.ready)
  `WAVHP_ASSERT_NOW(a_bad_zero, clk, rst_n, out_ch.valid && out_ch.status,
    out_ch.data_bytes == '0 && out_ch.bits_per_sample == '0 && !out_ch.stereo)
  `WAVHP_ASSERT_NOW(a_ok_bits, clk, rst_n, out_ch.valid && !out_ch.status,
    out_ch.bits_per_sample == 5'd0 || out_ch.bits_per_sample == 5'd8 ||
    out_ch.bits_per_sample == 5'd16)

endmodule

### tb/wav_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module wav_header_parser_unit_tb;
  import wavhp_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 30;
  localparam int unsigned FAST_DIV = 8;
  localparam int unsigned SLOW_DIV = 64;

  typedef enum logic [2:0] {PH_WAIT, PH_RIFF, PH_HDR, PH_FMT, PH_SKIP, PH_DONE} parse_phase_e;
  typedef enum logic [1:0] {NO_VERDICT, VERDICT_OK, VERDICT_BAD} verdict_e;

  typedef struct packed {
    logic              status;
    logic [CNT_W-1:0]  data_bytes;
    logic              stereo;
    logic [RES_W-1:0]  bits_per_sample;
    logic [RATE_W-1:0] sample_rate;
    logic [CMP_W-1:0]  timer_compare;
    logic              slow_prescaler;
  } header_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CLK_W-1:0] cfg_wdata;

  wavhp_in_if  in_if();
  wavhp_out_if out_if();

  wav_header_parser_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // parser state tracked by the testbench
  parse_phase_e      phase_m;
  logic [CNT_W-1:0]  count_m;
  logic [ID_W-1:0]   id_m;
  logic [CNT_W-1:0]  size_m;
  logic              stereo_m;
  logic [RES_W-1:0]  res_m;
  logic [RATE_W-1:0] rate_m;
  logic [CMP_W-1:0]  cmp_m;
  logic              slow_m;
  logic [CLK_W-1:0]  clock_hz_m;

  header_result_t expected_headers[$];
  header_result_t want_hdr;
  logic [7:0]     file_buf[$];

  int  mismatches;
  int  results_seen;
  int  live_bytes;
  int  stalled_cycles;
  bit  hold_req;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got_v, want_v);
    end
  endtask

  function automatic void clear_file_state();
    count_m  = '0;
    id_m     = '0;
    size_m   = '0;
    stereo_m = 1'b0;
    res_m    = '0;
    rate_m   = '0;
    cmp_m    = '0;
    slow_m   = 1'b0;
  endfunction

  function automatic logic [RATE_W-1:0] timer_div(input int unsigned pre);
    int unsigned q;
    q = (clock_hz_m / pre) / rate_m;
    return RATE_W'(q - 1);
  endfunction

  function automatic void track_header(input logic [7:0] b, input logic first_b,
                                       input logic last_b);
    verdict_e          verdict;
    logic [CNT_W-1:0]  off;
    logic [CNT_W-1:0]  data_len;
    logic [RATE_W-1:0] v;
    header_result_t    r;
    verdict  = NO_VERDICT;
    data_len = '0;
    r        = '0;
    if (first_b) begin
      clear_file_state();
      phase_m = PH_RIFF;
    end
    if (phase_m == PH_WAIT || phase_m == PH_DONE) return;
    live_bytes++;
    case (phase_m)
      PH_RIFF: begin
        if (count_m >= OFF_RIFF_ID) id_m = {b, id_m[ID_W-1:8]};
        count_m++;
        if (count_m == OFF_RIFF_LAST + 1) begin
          if (id_m == ID_WAVE) begin
            phase_m = PH_HDR;
            count_m = '0;
          end else begin
            verdict = VERDICT_BAD;
          end
        end
      end
      PH_HDR: begin
        if (count_m < OFF_ID_END) id_m = {b, id_m[ID_W-1:8]};
        else size_m = {b, size_m[CNT_W-1:8]};
        count_m++;
        if (count_m == OFF_HDR_LAST + 1) begin
          count_m = '0;
          if (id_m == ID_FMT) begin
            if (size_m < FMT_MIN || size_m > FMT_MAX) verdict = VERDICT_BAD;
            else phase_m = PH_FMT;
          end else if (id_m == ID_DATA) begin
            verdict  = VERDICT_OK;
            data_len = size_m;
          end else if (id_m == ID_LIST || id_m == ID_FACT) begin
            if (size_m != 0) phase_m = PH_SKIP;
          end else begin
            verdict = VERDICT_BAD;
          end
        end
      end
      PH_FMT: begin
        off = count_m;
        if (off == OFF_FMT_TAG && b != FMT_PCM) verdict = VERDICT_BAD;
        if (off == OFF_FMT_CH) begin
          if (b != CH_MONO && b != CH_STEREO) verdict = VERDICT_BAD;
          else stereo_m = (b == CH_STEREO);
        end
        if (off == OFF_FMT_RLO) rate_m = {8'h00, b};
        if (off == OFF_FMT_RHI) begin
          rate_m[15:8] = b;
          if (rate_m == 0) begin
            verdict = VERDICT_BAD;
          end else begin
            v      = timer_div(FAST_DIV);
            slow_m = 1'b0;
            if (v > CMP_LIMIT) begin
              v      = timer_div(SLOW_DIV);
              slow_m = 1'b1;
            end
            cmp_m = v[CMP_W-1:0];
          end
        end
        if (off == OFF_FMT_BITS) begin
          if (b != RES_8 && b != RES_16) verdict = VERDICT_BAD;
          else res_m = b[RES_W-1:0];
        end
        count_m++;
        if (verdict == NO_VERDICT && count_m == size_m) begin
          phase_m = PH_HDR;
          count_m = '0;
        end
      end
      default: begin
        count_m++;
        if (count_m == size_m) begin
          phase_m = PH_HDR;
          count_m = '0;
        end
      end
    endcase
    if (verdict == NO_VERDICT) begin
      if (!last_b) return;
      verdict = VERDICT_BAD;
    end
    phase_m  = PH_DONE;
    r.status = (verdict == VERDICT_BAD);
    if (verdict == VERDICT_OK) begin
      r.data_bytes      = data_len;
      r.stereo          = stereo_m;
      r.bits_per_sample = res_m;
      r.sample_rate     = rate_m;
      r.timer_compare   = cmp_m;
      r.slow_prescaler  = slow_m;
    end
    expected_headers.push_back(r);
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_headers.size() == 0) begin
        report_mismatch("unexpected result", out_if.data_bytes, '0);
      end else begin
        want_hdr = expected_headers.pop_front();
        if (out_if.status !== want_hdr.status)
          report_mismatch("status", out_if.status, want_hdr.status);
        if (out_if.data_bytes !== want_hdr.data_bytes)
          report_mismatch("data_bytes", out_if.data_bytes, want_hdr.data_bytes);
        if (out_if.stereo !== want_hdr.stereo)
          report_mismatch("stereo", out_if.stereo, want_hdr.stereo);
        if (out_if.bits_per_sample !== want_hdr.bits_per_sample)
          report_mismatch("bits_per_sample", out_if.bits_per_sample,
                          want_hdr.bits_per_sample);
        if (out_if.sample_rate !== want_hdr.sample_rate)
          report_mismatch("sample_rate", out_if.sample_rate, want_hdr.sample_rate);
        if (out_if.timer_compare !== want_hdr.timer_compare)
          report_mismatch("timer_compare", out_if.timer_compare, want_hdr.timer_compare);
        if (out_if.slow_prescaler !== want_hdr.slow_prescaler)
          report_mismatch("slow_prescaler", out_if.slow_prescaler,
                          want_hdr.slow_prescaler);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side ready, with a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first_b, input logic last_b);
    if (!no_idle && $urandom_range(99) < 37) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.byte_value <= b;
    in_if.first_byte <= first_b;
    in_if.last_byte  <= last_b;
    do @(posedge clk); while (!in_if.ready);
    track_header(b, first_b, last_b);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    cfg_wdata <= hz;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    clock_hz_m = hz;
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) file_buf.push_back(8'($urandom()));
  endtask

  task automatic build_wav(input logic [7:0] tag, input logic [7:0] chans,
                           input logic [15:0] rate, input logic [7:0] res_bits,
                           input logic [31:0] fmt_size, input int fmt_count,
                           input int skip_count, input logic [31:0] data_size);
    int n;
    file_buf.delete();
    put_word($urandom());
    put_word($urandom());
    put_word(ID_WAVE);
    for (int i = 0; i < skip_count; i++) begin
      n = $urandom_range(0, 6);
      put_word($urandom_range(1) ? ID_LIST : ID_FACT);
      put_word(n);
      put_noise(n);
    end
    for (int i = 0; i < fmt_count; i++) begin
      if (i > 0) begin
        chans    = $urandom_range(1) ? CH_STEREO : CH_MONO;
        rate     = 16'($urandom_range(1, 65535));
        res_bits = $urandom_range(1) ? RES_16 : RES_8;
      end
      put_word(ID_FMT);
      put_word(fmt_size);
      file_buf.push_back(tag);
      put_noise(1);
      file_buf.push_back(chans);
      put_noise(1);
      file_buf.push_back(rate[7:0]);
      file_buf.push_back(rate[15:8]);
      put_noise(8);
      file_buf.push_back(res_bits);
      put_noise(1);
      for (int k = 16; k < fmt_size && k < 110; k++) put_noise(1);
    end
    put_word(ID_DATA);
    put_word(data_size);
    put_noise($urandom_range(0, 2));
  endtask

  task automatic send_file(input int cut, input logic mark_last);
    for (int i = 0; i < cut; i++) send_byte(file_buf[i], i == 0, mark_last && i == cut - 1);
  endtask

  task automatic test_stray_bytes();
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd22050, RES_8, 32'd16, 1, 0, 32'd64);
    send_file(30, 1'b0);
    send_file(file_buf.size(), 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_good_files();
    build_wav(FMT_PCM, CH_MONO, 16'd8000, RES_8, 32'd16, 1, 0, 32'd1000);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_STEREO, 16'hFFFF, RES_16, FMT_MAX, 1, 2, 32'hFFFF_FFFF);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd1, RES_16, 32'd18, 1, 1, 32'd0);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_STEREO, 16'd7812, RES_8, 32'd16, 2, 0, $urandom());
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd7781, RES_16, 32'd16, 1, 0, $urandom());
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd8000, RES_8, 32'd16, 0, 1, $urandom());
    send_file(file_buf.size(), 1'b1);
    wait_idle();
  endtask

  task automatic test_bad_fields();
    build_wav(FMT_PCM, CH_MONO, 16'd8000, RES_8, 32'd16, 1, 0, 32'd8);
    file_buf[8] = 8'h00;
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd8000, RES_8, 32'd16, 1, 0, 32'd8);
    file_buf[12] = 8'h58;
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd8000, RES_8, FMT_MIN - 1, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_MONO, 16'd8000, RES_8, FMT_MAX + 1, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(8'h00, CH_MONO, 16'd8000, RES_8, 32'd16, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, 8'd0, 16'd8000, RES_8, 32'd16, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, 8'd3, 16'd8000, RES_8, 32'd16, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_STEREO, 16'd8000, 8'd7, 32'd16, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_STEREO, 16'd8000, 8'd24, 32'd16, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    build_wav(FMT_PCM, CH_STEREO, 16'd0, RES_16, 32'd16, 1, 0, 32'd8);
    send_file(file_buf.size(), 1'b1);
    wait_idle();
  endtask

  task automatic test_early_end();
    build_wav(FMT_PCM, CH_STEREO, 16'd44100, RES_16, 32'd16, 1, 0, 32'd8);
    send_file(5, 1'b1);
    send_file(12, 1'b1);
    send_file(27, 1'b1);
    send_file(36, 1'b1);
    // skip chunk cut in its body, at its header and on its last byte
    file_buf.delete();
    put_word($urandom());
    put_word($urandom());
    put_word(ID_WAVE);
    put_word(ID_LIST);
    put_word(32'd4);
    put_noise(4);
    send_file(22, 1'b1);
    send_file(20, 1'b1);
    send_file(24, 1'b1);
    wait_idle();
  endtask

  task automatic test_clock_settings();
    logic [CLK_W-1:0] hz_list [6];
    hz_list = '{27'd1, 27'd100000000, 27'd0, 27'h7FF_FFFF, 27'd44100, CLOCK_HZ_RST};
    for (int i = 0; i < 6; i++) begin
      wait_idle();
      write_clock(hz_list[i]);
      build_wav(FMT_PCM, CH_MONO, 16'd1, RES_8, 32'd16, 1, 0, $urandom());
      send_file(file_buf.size(), 1'b1);
      build_wav(FMT_PCM, CH_STEREO, 16'hFFFF, RES_16, 32'd16, 1, 0, $urandom());
      send_file(file_buf.size(), 1'b1);
      build_wav(FMT_PCM, CH_STEREO, 16'($urandom_range(1, 65535)), RES_16, 32'd16, 1, 0,
                $urandom());
      send_file(file_buf.size(), 1'b1);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) begin
      build_wav(FMT_PCM, CH_MONO, 16'($urandom_range(1, 65535)), RES_8, 32'd16, 1, 0,
                $urandom());
      if (i[0]) file_buf[9] = 8'h00;
      send_file(file_buf.size(), 1'b1);
    end
    wait_idle();
  endtask

  task automatic random_file();
    logic [7:0]  tag;
    logic [7:0]  chans;
    logic [7:0]  res_bits;
    logic [15:0] rate;
    logic [31:0] fmt_size;
    int          fmt_count;
    int          cut;
    tag      = ($urandom_range(99) < 95) ? FMT_PCM : 8'($urandom());
    chans    = ($urandom_range(99) < 92) ? ($urandom_range(1) ? CH_STEREO : CH_MONO)
                                         : 8'($urandom());
    res_bits = ($urandom_range(99) < 92) ? ($urandom_range(1) ? RES_16 : RES_8)
                                         : 8'($urandom());
    case ($urandom_range(19))
      0:       rate = 16'd0;
      1:       rate = 16'd1;
      2:       rate = 16'hFFFF;
      default: rate = 16'($urandom());
    endcase
    case ($urandom_range(19))
      0:       fmt_size = $urandom_range(0, 15);
      1:       fmt_size = $urandom_range(101, 130);
      2:       fmt_size = $urandom();
      3, 4:    fmt_size = $urandom_range(25, 100);
      default: fmt_size = $urandom_range(16, 24);
    endcase
    case ($urandom_range(19))
      0:       fmt_count = 0;
      1, 2:    fmt_count = 2;
      default: fmt_count = 1;
    endcase
    build_wav(tag, chans, rate, res_bits, fmt_size, fmt_count, $urandom_range(0, 2),
              $urandom());
    if ($urandom_range(9) == 0) file_buf[$urandom_range(file_buf.size() - 1)] = $urandom();
    cut = file_buf.size();
    if ($urandom_range(9) == 0) cut = $urandom_range(1, file_buf.size());
    send_file(cut, $urandom_range(7) != 0);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_files();
    int               start_results;
    int               start_bytes;
    int               p;
    logic [CLK_W-1:0] hz;
    start_results = results_seen;
    start_bytes   = live_bytes;
    p             = 0;
    while (live_bytes - start_bytes < 700 || results_seen - start_results < 48) begin
      wait_idle();
      case (p % 4)
        0:       hz = CLK_W'($urandom_range(1, 100000000));
        1:       hz = CLK_W'($urandom_range(1, 2000000));
        2:       hz = CLOCK_HZ_RST;
        default: hz = CLK_W'($urandom_range(8000000, 100000000));
      endcase
      write_clock(hz);
      no_idle = (p == 2);
      repeat (12) random_file();
      p++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.byte_value <= '0;
    in_if.first_byte <= 1'b0;
    in_if.last_byte  <= 1'b0;
    clock_hz_m = CLOCK_HZ_RST;
    phase_m    = PH_WAIT;
    clear_file_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_bytes();
    test_good_files();
    test_bad_fields();
    test_early_end();
    test_clock_settings();
    test_backpressure();
    test_random_files();
    wait_idle();
    if (mismatches == 0 && expected_headers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
